FILE: design/interval_point_greedy_matcher_core_macros.svh
// Assertion macros used by the matcher RTL.
// Depends on nothing; expects signals named clock and reset in the including module.
`ifndef INTERVAL_POINT_GREEDY_MATCHER_CORE_MACROS_SVH
`define INTERVAL_POINT_GREEDY_MATCHER_CORE_MACROS_SVH

// Implication checked every cycle outside reset.
`define IPGM_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) else $error(msg);

// Implication checked in the cycle after the antecedent, outside reset.
`define IPGM_ASSERT_NXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);

`endif

FILE: design/ipgm_pkg.sv
// Shared constants, codes and memory control structs for the matcher.
// Depends on nothing.
`default_nettype none
package ipgm_pkg;
   localparam int MAX_REQUESTS  = 4096;
   localparam int MAX_SLOTS     = 4096;
   localparam int LEVEL_BITS    = 10;
   localparam int FIELD_BITS    = 10;
   localparam int COUNT_BITS    = 13;
   localparam int LEVELS        = 1 << LEVEL_BITS;
   localparam int REQ_IDX_BITS  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int REQ_CNT_BITS  = $clog2(MAX_REQUESTS + 1);
   localparam int SLOT_CNT_BITS = $clog2(MAX_SLOTS + 1);
   localparam int SUM_BITS      = FIELD_BITS + SLOT_CNT_BITS;
   localparam int ENTRY_BITS    = 2 * LEVEL_BITS;

   typedef enum logic [1:0] {
      FUNC_LOAD_REQ  = 2'd0,
      FUNC_LOAD_SLOT = 2'd1,
      FUNC_START     = 2'd2
   } func_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SLOT_ADD,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_M_RD,
      ST_M_CHK,
      ST_S_RD,
      ST_S_CHK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    wr_en;
      logic [REQ_IDX_BITS-1:0] wr_addr;
      logic [ENTRY_BITS-1:0]   wr_data;
      logic                    rd_en;
      logic [REQ_IDX_BITS-1:0] rd_addr;
   } req_mem_ctl_type;

   typedef struct packed {
      logic                  wr_en;
      logic [LEVEL_BITS-1:0] wr_addr;
      logic [SUM_BITS-1:0]   wr_data;
      logic                  rd_en;
      logic [LEVEL_BITS-1:0] rd_addr;
   } lvl_mem_ctl_type;
endpackage
`default_nettype wire

FILE: design/ipgm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none
module ipgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

FILE: design/ipgm_ctrl.sv
// Sequencer and shared compare/decrement datapath of the matcher.
// Depends on ipgm_pkg and the assertion macro header.
`default_nettype none
`include "interval_point_greedy_matcher_core_macros.svh"
module ipgm_ctrl (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   input  wire logic [1:0]                       req_func,
   input  wire logic [ipgm_pkg::FIELD_BITS-1:0]  req_window_low,
   input  wire logic [ipgm_pkg::FIELD_BITS-1:0]  req_window_high,
   input  wire logic [ipgm_pkg::FIELD_BITS-1:0]  req_slot_level,
   input  wire logic [ipgm_pkg::FIELD_BITS-1:0]  req_slot_supply,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   output      logic [ipgm_pkg::COUNT_BITS-1:0]  rsp_served_count,
   output      logic                             rsp_overflow,
   output      ipgm_pkg::req_mem_ctl_type        rq_ctl,
   input  wire logic [ipgm_pkg::ENTRY_BITS-1:0]  rq_rd,
   output      ipgm_pkg::lvl_mem_ctl_type        tot_ctl,
   input  wire logic [ipgm_pkg::SUM_BITS-1:0]    tot_rd,
   output      ipgm_pkg::lvl_mem_ctl_type        scr_ctl,
   input  wire logic [ipgm_pkg::SUM_BITS-1:0]    scr_rd
);
   import ipgm_pkg::*;

   localparam logic [LEVEL_BITS-1:0] LVL_LAST = LEVEL_BITS'(LEVELS - 1);

   state_type                state_ff, state_in;
   logic [REQ_CNT_BITS-1:0]  req_total_ff, req_total_in;
   logic [SLOT_CNT_BITS-1:0] slot_total_ff, slot_total_in;
   logic                     dropped_ff, dropped_in;
   logic [LEVEL_BITS-1:0]    lvl_ff, lvl_in;
   logic [LEVEL_BITS-1:0]    h_ff, h_in;
   logic [REQ_IDX_BITS-1:0]  r_ff, r_in;
   logic [COUNT_BITS-1:0]    served_ff, served_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;
   logic                     rsp_ovf_ff, rsp_ovf_in;
   logic [FIELD_BITS-1:0]    sup_ff, sup_in;
   logic                     adv;
   logic                     last_req;
   logic [LEVEL_BITS-1:0]    ent_lo, ent_hi;

   assign ent_lo   = rq_rd[LEVEL_BITS-1:0];
   assign ent_hi   = rq_rd[ENTRY_BITS-1:LEVEL_BITS];
   assign last_req = (REQ_CNT_BITS'(r_ff) + REQ_CNT_BITS'(1)) == req_total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         req_total_ff  <= '0;
         slot_total_ff <= '0;
         dropped_ff    <= 1'b0;
         lvl_ff        <= '0;
         h_ff          <= '0;
         r_ff          <= '0;
         served_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         req_total_ff  <= req_total_in;
         slot_total_ff <= slot_total_in;
         dropped_ff    <= dropped_in;
         lvl_ff        <= lvl_in;
         h_ff          <= h_in;
         r_ff          <= r_in;
         served_ff     <= served_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_ovf_ff   <= rsp_ovf_in;
      sup_ff       <= sup_in;
   end

   always_comb begin
      state_in      = state_ff;
      req_total_in  = req_total_ff;
      slot_total_in = slot_total_ff;
      dropped_in    = dropped_ff;
      lvl_in        = lvl_ff;
      h_in          = h_ff;
      r_in          = r_ff;
      served_in     = served_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_count_in  = rsp_count_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      sup_in        = sup_ff;
      req_tready    = 1'b0;
      adv           = 1'b0;
      rq_ctl        = '0;
      tot_ctl       = '0;
      scr_ctl       = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            tot_ctl.wr_en   = 1'b1;
            tot_ctl.wr_addr = lvl_ff;
            if (lvl_ff == LVL_LAST) begin
               lvl_in   = '0;
               state_in = ST_IDLE;
            end else begin
               lvl_in = lvl_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_func)
                  FUNC_LOAD_REQ: begin
                     if (req_total_ff < REQ_CNT_BITS'(MAX_REQUESTS)) begin
                        rq_ctl.wr_en   = 1'b1;
                        rq_ctl.wr_addr = req_total_ff[REQ_IDX_BITS-1:0];
                        rq_ctl.wr_data = {req_window_high[LEVEL_BITS-1:0],
                                          req_window_low[LEVEL_BITS-1:0]};
                        req_total_in   = req_total_ff + 1'b1;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  FUNC_LOAD_SLOT: begin
                     if (slot_total_ff < SLOT_CNT_BITS'(MAX_SLOTS)) begin
                        tot_ctl.rd_en   = 1'b1;
                        tot_ctl.rd_addr = req_slot_level[LEVEL_BITS-1:0];
                        lvl_in          = req_slot_level[LEVEL_BITS-1:0];
                        sup_in          = req_slot_supply;
                        slot_total_in   = slot_total_ff + 1'b1;
                        state_in        = ST_SLOT_ADD;
                     end else begin
                        dropped_in = 1'b1;
                     end
                  end
                  FUNC_START: begin
                     lvl_in   = '0;
                     state_in = ST_COPY_RD;
                  end
                  default: ;
               endcase
            end
         end
         ST_SLOT_ADD: begin
            tot_ctl.wr_en   = 1'b1;
            tot_ctl.wr_addr = lvl_ff;
            tot_ctl.wr_data = tot_rd + SUM_BITS'(sup_ff);
            lvl_in          = '0;
            state_in        = ST_IDLE;
         end
         ST_COPY_RD: begin
            tot_ctl.rd_en   = 1'b1;
            tot_ctl.rd_addr = lvl_ff;
            state_in        = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            scr_ctl.wr_en   = 1'b1;
            scr_ctl.wr_addr = lvl_ff;
            scr_ctl.wr_data = tot_rd;
            if (lvl_ff == LVL_LAST) begin
               lvl_in    = '0;
               h_in      = '0;
               r_in      = '0;
               served_in = '0;
               state_in  = (req_total_ff == '0) ? ST_DONE : ST_M_RD;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_COPY_RD;
            end
         end
         ST_M_RD: begin
            rq_ctl.rd_en   = 1'b1;
            rq_ctl.rd_addr = r_ff;
            state_in       = ST_M_CHK;
         end
         ST_M_CHK: begin
            if ((ent_hi == h_ff) && (ent_lo <= ent_hi)) begin
               lvl_in   = ent_lo;
               state_in = ST_S_RD;
            end else begin
               adv = 1'b1;
            end
         end
         ST_S_RD: begin
            scr_ctl.rd_en   = 1'b1;
            scr_ctl.rd_addr = lvl_ff;
            state_in        = ST_S_CHK;
         end
         ST_S_CHK: begin
            if (scr_rd != '0) begin
               scr_ctl.wr_en   = 1'b1;
               scr_ctl.wr_addr = lvl_ff;
               scr_ctl.wr_data = scr_rd - 1'b1;
               served_in       = served_ff + 1'b1;
               adv             = 1'b1;
            end else if (lvl_ff == h_ff) begin
               adv = 1'b1;
            end else begin
               lvl_in   = lvl_ff + 1'b1;
               state_in = ST_S_RD;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = served_ff;
               rsp_ovf_in   = dropped_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
      if (adv) begin
         if (last_req) begin
            r_in = '0;
            if (h_ff == LVL_LAST) begin
               state_in = ST_DONE;
            end else begin
               h_in     = h_ff + 1'b1;
               state_in = ST_M_RD;
            end
         end else begin
            r_in     = r_ff + 1'b1;
            state_in = ST_M_RD;
         end
      end
   end

   assign rsp_tvalid       = rsp_valid_ff;
   assign rsp_served_count = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   `IPGM_ASSERT_IMP(a_no_accept_in_clear, state_ff == ST_CLEAR, !req_tready, "accept during clear")
   `IPGM_ASSERT_IMP(a_served_bounded, rsp_valid_ff, REQ_CNT_BITS'(rsp_count_ff) <= req_total_ff, "served above total")
   `IPGM_ASSERT_NXT(a_serve_counts, (state_ff == ST_S_CHK) && (scr_rd != '0), served_ff == $past(served_ff) + 1'b1, "serve not counted")
endmodule
`default_nettype wire

FILE: design/interval_point_greedy_matcher_core.sv
// Operation: a request beat is written to the request store when taken; a slot beat reads the
// level's total, then adds its supply; a start copies every level total into the scratch table,
// then makes 2^LEVEL_BITS passes over the request store, searching the scratch table per match.
// Throughput: one item at a time; ready is high only while idle, low during a slot add or a match.
// Reset: synchronous, active high; afterwards a clearing pass over all 2^LEVEL_BITS levels zeroes
// the per-level supply table before the first beat is taken.
`default_nettype none
module interval_point_greedy_matcher_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // tuser: func[1:0]
   input  wire logic [1:0]  req_tuser,
   // tdata: window_low[9:0], window_high[19:10], slot_level[29:20], slot_supply[39:30]
   input  wire logic [39:0] req_tdata,
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata: served_count[12:0], overflow[13], zero fill[15:14]
   output      logic [15:0] rsp_tdata
);
   import ipgm_pkg::*;

   req_mem_ctl_type         rq_ctl;
   lvl_mem_ctl_type         tot_ctl;
   lvl_mem_ctl_type         scr_ctl;
   logic [ENTRY_BITS-1:0]   rq_rd;
   logic [SUM_BITS-1:0]     tot_rd;
   logic [SUM_BITS-1:0]     scr_rd;
   logic [COUNT_BITS-1:0]   served_count;
   logic                    overflow;

   ipgm_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_func         (req_tuser),
      .req_window_low   (req_tdata[9:0]),
      .req_window_high  (req_tdata[19:10]),
      .req_slot_level   (req_tdata[29:20]),
      .req_slot_supply  (req_tdata[39:30]),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_served_count (served_count),
      .rsp_overflow     (overflow),
      .rq_ctl           (rq_ctl),
      .rq_rd            (rq_rd),
      .tot_ctl          (tot_ctl),
      .tot_rd           (tot_rd),
      .scr_ctl          (scr_ctl),
      .scr_rd           (scr_rd)
   );

   ipgm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_REQUESTS)) u_req_store (
      .clock   (clock),
      .wr_en   (rq_ctl.wr_en),
      .wr_addr (rq_ctl.wr_addr),
      .wr_data (rq_ctl.wr_data),
      .rd_en   (rq_ctl.rd_en),
      .rd_addr (rq_ctl.rd_addr),
      .rd_data (rq_rd)
   );

   ipgm_ram #(.WIDTH(SUM_BITS), .DEPTH(LEVELS)) u_level_total (
      .clock   (clock),
      .wr_en   (tot_ctl.wr_en),
      .wr_addr (tot_ctl.wr_addr),
      .wr_data (tot_ctl.wr_data),
      .rd_en   (tot_ctl.rd_en),
      .rd_addr (tot_ctl.rd_addr),
      .rd_data (tot_rd)
   );

   ipgm_ram #(.WIDTH(SUM_BITS), .DEPTH(LEVELS)) u_level_scratch (
      .clock   (clock),
      .wr_en   (scr_ctl.wr_en),
      .wr_addr (scr_ctl.wr_addr),
      .wr_data (scr_ctl.wr_data),
      .rd_en   (scr_ctl.rd_en),
      .rd_addr (scr_ctl.rd_addr),
      .rd_data (scr_rd)
   );

   assign rsp_tdata = {2'b00, overflow, served_count};
endmodule
`default_nettype wire
